[rtl/insertion_sort_by_key_top_defines.svh]
// Assertion macros used by the insertion sort controller.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef INSERTION_SORT_BY_KEY_TOP_DEFINES_SVH
`define INSERTION_SORT_BY_KEY_TOP_DEFINES_SVH

// Plain property, checked out of reset.
`define ISBK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ISBK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ISBK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/isbk_pkg.sv]
// Package for the insertion sort block: payload types, command/status structs
// and parameter defaults. No dependencies.
package isbk_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int FIELD_BITS   = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] sort_key;
        logic [FIELD_BITS-1:0] record_id;
        logic                  last_in;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] out_key;
        logic [FIELD_BITS-1:0] out_id;
        logic                  last_out;
        logic                  overflow;
    } t_out_item;

    typedef struct packed {
        logic in_load;
        logic rd_en;
        logic wr_en;
        logic wr_new;
        logic out_load;
        logic out_last;
        logic out_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_gt;
    } t_dp_status;

endpackage

[rtl/isbk_stream_if.sv]
// Valid/ready stream interface carrying one payload item per transfer.
// Depends on nothing; payload type is set by the instantiating module.
interface isbk_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/isbk_ctrl.sv]
// Controller FSM for the insertion sort: entry count, shift position,
// emission index and overflow flag. Depends on isbk_pkg and the defines header.
`include "insertion_sort_by_key_top_defines.svh"

module isbk_ctrl
    import isbk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_last,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  t_dp_status                 i_status,
    output t_dp_cmd                    o_cmd,
    output logic [$clog2(DEPTH)-1:0]   o_rd_addr,
    output logic [$clog2(DEPTH)-1:0]   o_wr_addr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRD   = 3'd1;
    localparam logic [2:0] S_SCMP  = 3'd2;
    localparam logic [2:0] S_ERD   = 3'd3;
    localparam logic [2:0] S_ELD   = 3'd4;
    localparam logic [2:0] S_EWAIT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_drop, n_drop;
    logic          r_last, n_last;
    logic          idx_final;

    assign idx_final = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_drop    = r_drop;
        n_last    = r_last;
        o_cmd     = '0;
        o_rd_addr = r_pos - AW'(1);
        o_wr_addr = r_pos;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.out_last = idx_final;
        o_cmd.out_ovf  = r_drop;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_last = i_last;
                    n_idx  = '0;
                    if (r_count == FULL) begin
                        n_drop = 1'b1;
                        if (i_last) begin
                            n_state = S_ERD;
                        end
                    end else begin
                        n_pos   = r_count[AW-1:0];
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_pos == '0) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_new = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_ERD : S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_status.rd_gt) begin
                    n_pos   = r_pos - AW'(1);
                    n_state = S_SRD;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_ERD : S_IDLE;
                end
            end
            S_ERD: begin
                o_rd_addr   = r_idx;
                o_cmd.rd_en = 1'b1;
                n_state = S_ELD;
            end
            S_ELD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (idx_final) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_drop  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_drop  <= n_drop;
            r_last  <= n_last;
        end
    end

    `ISBK_ASSERT(a_count_bound, r_count <= FULL, "entry count beyond depth")
    `ISBK_ASSERT_IMP(a_wr_state, o_cmd.wr_en, (r_state == S_SRD) || (r_state == S_SCMP), "store write outside insertion")
    `ISBK_ASSERT_NXT(a_run_clears, (r_state == S_EWAIT) && i_out_ready && idx_final, (r_count == '0) && !r_drop, "store not emptied after final transfer")
    `ISBK_ASSERT_NXT(a_insert_inc, (r_state == S_SCMP) && !i_status.rd_gt, r_count == $past(r_count) + CW'(1), "count not advanced on insertion")

endmodule

[rtl/isbk_datapath.sv]
// Datapath for the insertion sort: key/id store memories, captured record,
// compare and output register. Depends on isbk_pkg.
module isbk_datapath
    import isbk_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_in_item                 i_item,
    input  t_dp_cmd                  i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    output t_dp_status               o_status,
    output t_out_item                o_item
);

    localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;

    logic [KW-1:0]         key_mem [DEPTH];
    logic [FIELD_BITS-1:0] id_mem  [DEPTH];

    logic [KW-1:0]         r_key;
    logic [FIELD_BITS-1:0] r_id;
    logic [KW-1:0]         r_rd_key;
    logic [FIELD_BITS-1:0] r_rd_id;
    logic [KW-1:0]         r_out_key;
    logic [FIELD_BITS-1:0] r_out_id;
    logic                  r_out_last;
    logic                  r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_key <= i_item.sort_key[KW-1:0];
            r_id  <= i_item.record_id;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= key_mem[i_rd_addr];
            r_rd_id  <= id_mem[i_rd_addr];
        end
        if (i_cmd.wr_en) begin
            key_mem[i_wr_addr] <= i_cmd.wr_new ? r_key : r_rd_key;
            id_mem[i_wr_addr]  <= i_cmd.wr_new ? r_id  : r_rd_id;
        end
        if (i_cmd.out_load) begin
            r_out_key  <= r_rd_key;
            r_out_id   <= r_rd_id;
            r_out_last <= i_cmd.out_last;
            r_out_ovf  <= i_cmd.out_ovf;
        end
    end

    // strictly greater: equal keys stay ahead, keeping the sort stable
    assign o_status.rd_gt = (r_rd_key > r_key);

    assign o_item.out_key  = FIELD_BITS'(r_out_key);
    assign o_item.out_id   = r_out_id;
    assign o_item.last_out = r_out_last;
    assign o_item.overflow = r_out_ovf;

endmodule

[rtl/insertion_sort_by_key_top.sv]
// Insertion sort top: each stored key strictly greater than a new record is read and shifted
// up one slot, then the record is written in place; a record that arrives while full is dropped.
// On the last record each result is read, loaded and presented, waiting on the sink's ready.
// Synchronous active-low reset empties the store and clears the overflow flag;
// store contents are not cleared and no pass over the memory is made.
// Depends on isbk_pkg, isbk_stream_if, isbk_ctrl and isbk_datapath.
module insertion_sort_by_key_top
    import isbk_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    isbk_stream_if.sink           i_in,
    isbk_stream_if.source         o_out
);

    localparam int AW = $clog2(DEPTH);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_in_item   in_item;
    t_out_item  out_item;
    logic       in_ready;
    logic       out_valid;

    assign in_item     = i_in.data;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;

    isbk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last      (in_item.last_in),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr)
    );

    isbk_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_item    (in_item),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_status  (status),
        .o_item    (out_item)
    );

endmodule
